// File: sv/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal block.
`default_nettype none

package vrt_pkg;

    localparam int MAX_CELLS_DEF   = 64;
    localparam int T_FRAC_BITS_DEF = 32;

    localparam int CRD_W = 32;   // Q16.16 coordinate
    localparam int RES_W = 31;   // cell size
    localparam int DEN_W = 33;   // divisor: cell size or |extent|
    localparam int CW    = 35;   // internal cell index
    localparam int TW    = 64;   // t_max / t_delta
    localparam int OUT_W = 16;   // emitted cell index
    localparam int ROW_W = 15;
    localparam int IDX_W = 3;

    localparam logic [TW-1:0] T_CAP = 64'h4000_0000_0000_0000;
    localparam logic [TW-1:0] T_INF = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_WEST   = 3'd0,
        REG_ORIGIN_SOUTH  = 3'd1,
        REG_ORIGIN_BOTTOM = 3'd2,
        REG_RES_EW        = 3'd3,
        REG_RES_NS        = 3'd4,
        REG_RES_TB        = 3'd5,
        REG_ROW_COUNT     = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_STEP
    } state_t;

    typedef enum logic [1:0] {
        JOB_CELL,
        JOB_CELL_END,
        JOB_TDELTA,
        JOB_TMAX
    } job_t;

endpackage

`default_nettype wire

// File: sv/vrt_ifs.sv
// Request channel interfaces: segment in, visited cell out, config write.
`default_nettype none

interface vrt_seg_if import vrt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CRD_W-1:0] start_x;
    logic signed [CRD_W-1:0] start_y;
    logic signed [CRD_W-1:0] start_z;
    logic signed [CRD_W-1:0] end_x;
    logic signed [CRD_W-1:0] end_y;
    logic signed [CRD_W-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface vrt_cell_if import vrt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] cell_col;
    logic signed [OUT_W-1:0] cell_row;
    logic signed [OUT_W-1:0] cell_depth;
    logic                    cell_valid;
    logic                    truncated;
    logic                    last;

    modport source (output valid, cell_col, cell_row, cell_depth, cell_valid,
                    truncated, last, input ready);
    modport sink (input valid, cell_col, cell_row, cell_depth, cell_valid,
                  truncated, last, output ready);
endinterface

interface vrt_cfg_if import vrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CRD_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/vrt_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module vrt_div import vrt_pkg::*; #(
    parameter int NW = RES_W + T_FRAC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NW-1:0]    dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NW-1:0]         quo,
    output logic [DEN_W-1:0]      rem
);

    localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[NW-1]};
        diff     = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = dvd_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: sv/voxel_ray_traversal.sv
// Top level: 3D voxel DDA traversal of one segment per request.
// Setup: 6 floor divisions plus 2 fraction divisions per moving axis (6 to 12 in all),
//   each run in turn on the one serial divider.
// Walk: one DDA step per cycle while the output register is free; up to MAX_CELLS+1 steps.
// One segment in flight; segment.ready rises again once its last result is staged.
// Reset (rst_n, async, low): config to origins 0, cell sizes 1.0, row_count 1; idle.
`default_nettype none

module voxel_ray_traversal import vrt_pkg::*; #(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    vrt_seg_if.sink    segment,
    vrt_cell_if.source visit,
    vrt_cfg_if.sink    cfg
);

    localparam int NW   = RES_W + T_FRAC_BITS;
    localparam int QW   = (NW > TW) ? NW : TW;
    localparam int CNTW = $clog2(MAX_CELLS + 1);

    // configuration
    logic signed [CRD_W-1:0] org_reg [3];
    logic [RES_W-1:0]        res_reg [3];
    logic [ROW_W-1:0]        row_count_reg;

    // latched segment
    logic signed [CRD_W-1:0] st_reg [3];
    logic signed [CRD_W-1:0] en_reg [3];

    // per-axis walk state
    logic signed [CW-1:0] cur_reg    [3];
    logic signed [CW-1:0] cend_reg   [3];
    logic                 neg_reg    [3];
    logic [TW-1:0]        tmax_reg   [3];
    logic [TW-1:0]        tdelta_reg [3];
    logic [RES_W-1:0]     off_reg;

    // sequencer
    state_t          state_reg, state_next;
    job_t            job_reg;
    logic [1:0]      axis_reg;
    logic [CNTW-1:0] count_reg;

    // pending cell and output register
    logic [OUT_W-1:0] pend_col_reg, pend_row_reg, pend_depth_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_col_reg, out_row_reg, out_depth_reg;
    logic             out_cv_reg, out_trunc_reg, out_last_reg;

    // control strobes
    logic seg_ready, div_start, step_go, accept;

    // divider hookup
    logic             div_done;
    logic [NW-1:0]    div_quo;
    logic [DEN_W-1:0] div_rem;
    logic [NW-1:0]    dividend;
    logic [DEN_W-1:0] divisor;

    // setup datapath for the current axis
    logic signed [CRD_W-1:0] s_cur, e_cur, org_cur;
    logic [RES_W-1:0]        res_cur;
    logic signed [CRD_W:0]   a_cur, b_cur, d_cur;
    logic [CRD_W:0]          abs_a, abs_b, abs_d;
    logic                    rising;
    logic [RES_W-1:0]        num_cur;
    logic                    res_neg, rem_nz;
    logic signed [CW-1:0]    q_cell, cell_val;
    logic [RES_W-1:0]        off_val;
    logic [QW-1:0]           quo_ext;
    logic [TW-1:0]           t_sat;
    logic                    d_zero, job_last, axis_last;

    // walk datapath
    logic                 sel [3];
    logic signed [CW-1:0] nxt_cell [3];
    logic [TW-1:0]        nxt_t    [3];
    logic [TW-1:0]        tsum     [3];
    logic                 stop_inf, hit, over, walk_done, trunc, finish, out_free, emit;

    assign accept = segment.valid && seg_ready;

    // ---------------- configuration port ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            org_reg[2]    <= '0;
            res_reg[0]    <= RES_W'(65536);
            res_reg[1]    <= RES_W'(65536);
            res_reg[2]    <= RES_W'(65536);
            row_count_reg <= ROW_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_ORIGIN_WEST:   org_reg[0]    <= cfg.data;
                REG_ORIGIN_SOUTH:  org_reg[1]    <= cfg.data;
                REG_ORIGIN_BOTTOM: org_reg[2]    <= cfg.data;
                REG_RES_EW:        res_reg[0]    <= cfg.data[RES_W-1:0];
                REG_RES_NS:        res_reg[1]    <= cfg.data[RES_W-1:0];
                REG_RES_TB:        res_reg[2]    <= cfg.data[RES_W-1:0];
                REG_ROW_COUNT:     row_count_reg <= cfg.data[ROW_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- segment latch ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg[0] <= segment.start_x;
            st_reg[1] <= segment.start_y;
            st_reg[2] <= segment.start_z;
            en_reg[0] <= segment.end_x;
            en_reg[1] <= segment.end_y;
            en_reg[2] <= segment.end_z;
        end
    end

    // ---------------- setup operands ----------------
    always_comb
    begin
        s_cur   = st_reg[axis_reg];
        e_cur   = en_reg[axis_reg];
        org_cur = org_reg[axis_reg];
        // a zero cell size acts as the smallest size, one LSB
        res_cur = (res_reg[axis_reg] == '0) ? RES_W'(1) : res_reg[axis_reg];
        a_cur   = {s_cur[CRD_W-1], s_cur} - {org_cur[CRD_W-1], org_cur};
        b_cur   = {e_cur[CRD_W-1], e_cur} - {org_cur[CRD_W-1], org_cur};
        d_cur   = {e_cur[CRD_W-1], e_cur} - {s_cur[CRD_W-1], s_cur};
        abs_a   = a_cur[CRD_W] ? (CRD_W+1)'(-a_cur) : a_cur;
        abs_b   = b_cur[CRD_W] ? (CRD_W+1)'(-b_cur) : b_cur;
        abs_d   = d_cur[CRD_W] ? (CRD_W+1)'(-d_cur) : d_cur;
        d_zero  = (d_cur == '0);
        rising  = s_cur < e_cur;
        // distance to the first boundary crossed, in world units
        num_cur = rising ? (res_cur - off_reg) : off_reg;

        unique case (job_reg)
            JOB_CELL:
            begin
                dividend = NW'(abs_a);
                divisor  = DEN_W'(res_cur);
            end
            JOB_CELL_END:
            begin
                dividend = NW'(abs_b);
                divisor  = DEN_W'(res_cur);
            end
            JOB_TDELTA:
            begin
                dividend = {res_cur, {T_FRAC_BITS{1'b0}}};
                divisor  = abs_d;
            end
            JOB_TMAX:
            begin
                dividend = {num_cur, {T_FRAC_BITS{1'b0}}};
                divisor  = abs_d;
            end
            default:
            begin
                dividend = '0;
                divisor  = abs_d;
            end
        endcase

        // floor division from magnitude quotient and remainder
        res_neg  = (job_reg == JOB_CELL) ? a_cur[CRD_W] : b_cur[CRD_W];
        rem_nz   = (div_rem != '0);
        q_cell   = div_quo[CW-1:0];
        cell_val = res_neg ? (-q_cell - CW'(rem_nz)) : q_cell;
        off_val  = (res_neg && rem_nz) ? (res_cur - div_rem[RES_W-1:0]) :
                   (res_neg ? '0 : div_rem[RES_W-1:0]);

        quo_ext  = QW'(div_quo);
        t_sat    = (quo_ext > QW'(T_CAP)) ? T_CAP : quo_ext[TW-1:0];

        job_last  = (job_reg == JOB_TMAX) || ((job_reg == JOB_CELL_END) && d_zero);
        axis_last = (axis_reg == 2'd2);
    end

    vrt_div #(
        .NW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // ---------------- walk step ----------------
    always_comb
    begin
        // ties: z before both, y before x
        sel[0]   = (tmax_reg[0] < tmax_reg[1]) && (tmax_reg[0] < tmax_reg[2]);
        sel[1]   = !(tmax_reg[0] < tmax_reg[1]) && (tmax_reg[1] < tmax_reg[2]);
        sel[2]   = !sel[0] && !sel[1];
        stop_inf = sel[2] && (tmax_reg[2] == T_INF);
        hit      = 1'b1;
        over     = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (sel[i])
                nxt_cell[i] = neg_reg[i] ? (cur_reg[i] - CW'(1)) : (cur_reg[i] + CW'(1));
            else
                nxt_cell[i] = cur_reg[i];
            tsum[i]  = tmax_reg[i] + tdelta_reg[i];
            nxt_t[i] = (tsum[i] > T_CAP) ? T_CAP : tsum[i];
            hit      = hit && (nxt_cell[i] == cend_reg[i]);
            over     = over || (neg_reg[i] ? (nxt_cell[i] < cend_reg[i])
                                           : (nxt_cell[i] > cend_reg[i]));
        end
        walk_done = stop_inf || hit || over;
        trunc     = !walk_done && (count_reg >= CNTW'(MAX_CELLS));
        finish    = walk_done || trunc;
        out_free  = !out_valid_reg || visit.ready;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (segment.valid) state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done)
                    state_next = (job_last && axis_last) ? ST_STEP : ST_ISSUE;
            end
            ST_STEP:  if (out_free && finish) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        seg_ready = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_ISSUE);
        step_go   = (state_reg == ST_STEP) && out_free;
        emit      = step_go && (finish || (count_reg != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_CELL;
            axis_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                job_reg   <= JOB_CELL;
                axis_reg  <= '0;
                count_reg <= '0;
            end
            else if ((state_reg == ST_WAIT) && div_done)
            begin
                if (job_last)
                begin
                    job_reg  <= JOB_CELL;
                    axis_reg <= axis_reg + 2'd1;
                end
                else
                    job_reg <= job_t'(job_reg + 2'd1);
            end
            else if (step_go && !finish)
                count_reg <= count_reg + CNTW'(1);

            // a new result may replace one taken in the same cycle
            if (emit)
                out_valid_reg <= 1'b1;
            else if (visit.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // setup results and walk registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WAIT) && div_done)
        begin
            unique case (job_reg)
                JOB_CELL:
                begin
                    cur_reg[axis_reg] <= cell_val;
                    neg_reg[axis_reg] <= !rising;
                    off_reg           <= off_val;
                end
                JOB_CELL_END:
                begin
                    cend_reg[axis_reg] <= cell_val;
                    if (d_zero)
                    begin
                        // flat axis never steps
                        tmax_reg[axis_reg]   <= T_INF;
                        tdelta_reg[axis_reg] <= T_INF;
                    end
                end
                JOB_TDELTA: tdelta_reg[axis_reg] <= t_sat;
                JOB_TMAX:   tmax_reg[axis_reg]   <= t_sat;
                default:    ;
            endcase
        end
        else if (step_go)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i] <= nxt_cell[i];
                if (sel[i])
                    tmax_reg[i] <= nxt_t[i];
            end
        end

        // hold each cell one step so the final one can carry last/truncated
        if (step_go && !finish)
        begin
            pend_col_reg   <= nxt_cell[0][OUT_W-1:0];
            pend_row_reg   <= OUT_W'(row_count_reg) - nxt_cell[1][OUT_W-1:0] - OUT_W'(1);
            pend_depth_reg <= nxt_cell[2][OUT_W-1:0];
        end

        if (emit)
        begin
            if (finish && (count_reg == '0))
            begin
                out_col_reg   <= '0;
                out_row_reg   <= '0;
                out_depth_reg <= '0;
                out_cv_reg    <= 1'b0;
                out_trunc_reg <= 1'b0;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_col_reg   <= pend_col_reg;
                out_row_reg   <= pend_row_reg;
                out_depth_reg <= pend_depth_reg;
                out_cv_reg    <= 1'b1;
                out_trunc_reg <= finish && trunc;
                out_last_reg  <= finish;
            end
        end
    end

    assign segment.ready    = seg_ready;
    assign visit.valid      = out_valid_reg;
    assign visit.cell_col   = out_col_reg;
    assign visit.cell_row   = out_row_reg;
    assign visit.cell_depth = out_depth_reg;
    assign visit.cell_valid = out_cv_reg;
    assign visit.truncated  = out_trunc_reg;
    assign visit.last       = out_last_reg;

endmodule

`default_nettype wire

// File: sv/vrt_checker.sv
// Port-level assertions for the voxel traversal block, bound to the top level.
`default_nettype none

module vrt_checker import vrt_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             seg_valid,
    input wire logic             seg_ready,
    input wire logic             vis_valid,
    input wire logic             vis_ready,
    input wire logic [OUT_W-1:0] vis_col,
    input wire logic [OUT_W-1:0] vis_row,
    input wire logic [OUT_W-1:0] vis_depth,
    input wire logic             vis_cell_valid,
    input wire logic             vis_truncated,
    input wire logic             vis_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vis_valid && !vis_ready |=> vis_valid && $stable(vis_col) && $stable(vis_row)
            && $stable(vis_depth) && $stable(vis_last) && $stable(vis_cell_valid))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |=> !seg_ready)
        else $error("second request taken during setup");

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        vis_valid && !vis_cell_valid |-> vis_last && !vis_truncated && vis_col == '0
            && vis_row == '0 && vis_depth == '0)
        else $error("malformed empty-run item");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        vis_valid && vis_truncated |-> vis_last && vis_cell_valid)
        else $error("truncated flag off the final cell");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .seg_valid      (segment.valid),
    .seg_ready      (segment.ready),
    .vis_valid      (visit.valid),
    .vis_ready      (visit.ready),
    .vis_col        (visit.cell_col),
    .vis_row        (visit.cell_row),
    .vis_depth      (visit.cell_depth),
    .vis_cell_valid (visit.cell_valid),
    .vis_truncated  (visit.truncated),
    .vis_last       (visit.last)
);

`default_nettype wire
